// ===== sv/cfpg_pkg.sv =====
`default_nettype none
package cfpg_pkg;

  localparam int unsigned HDR_W = 15;
  localparam int unsigned GAP_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HALF_W = 2;

  localparam logic [HDR_W-1:0] SHORT_HDR_RST = 15'd7936;
  localparam logic [HDR_W-1:0] LONG_HDR_RST = 15'd31744;
  localparam logic [GAP_W-1:0] GAP_RST = 16'd9600;

  // start bit, eight data bits, two stop bits
  localparam logic [HDR_W-1:0] FRAME_BITS = 15'd11;

  localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_HDR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_HDR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP_LEN = 2'd2;

  localparam logic [1:0] LEVEL_LOW = 2'd0;
  localparam logic [1:0] LEVEL_HIGH = 2'd1;
  localparam logic [1:0] LEVEL_SILENCE = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BYTES  = 2'd1,
    PH_START  = 2'd2,
    PH_END    = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [HDR_W-1:0]  bit_count;
    logic [HALF_W-1:0] half_count;
  } state_t;

  typedef struct packed {
    logic       chunk_is_last;
    logic       byte_is_last;
    logic       chunk_has_gap;
    logic       chunk_long_header;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             at_end;
    logic             byte_done;
    logic [GAP_W-1:0] pulse_length;
    logic [1:0]       pulse_level;
  } out_item_t;

  typedef struct packed {
    logic [HDR_W-1:0] short_header_bits;
    logic [HDR_W-1:0] long_header_bits;
    logic [GAP_W-1:0] gap_length;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/cfpg_step.sv =====
`default_nettype none
module cfpg_step (
  input  cfpg_pkg::state_t    state_i,
  input  cfpg_pkg::in_item_t  item_i,
  input  cfpg_pkg::cfg_t      cfg_i,
  output cfpg_pkg::state_t    state_o,
  output cfpg_pkg::out_item_t result_o
);
  import cfpg_pkg::*;

  state_t           eff;
  logic [HDR_W-1:0] bc_inc;
  logic [HDR_W-1:0] hdr_target;
  logic [2:0]       half_inc;
  logic [2:0]       bit_idx;
  logic             bit_val;
  logic [2:0]       half_limit;

  always_comb begin
    // chunk start without a gap falls straight into the header
    eff = state_i;
    if (state_i.phase == PH_START) begin
      eff.phase      = PH_HEADER;
      eff.bit_count  = '0;
      eff.half_count = '0;
    end

    bc_inc     = eff.bit_count + 15'd1;
    half_inc   = {1'b0, eff.half_count} + 3'd1;
    hdr_target = item_i.chunk_long_header ? cfg_i.long_header_bits : cfg_i.short_header_bits;
    bit_idx    = eff.bit_count[2:0] - 3'd1;

    if (eff.bit_count == '0) begin
      bit_val = 1'b0;
    end else if (eff.bit_count <= 15'd8) begin
      bit_val = item_i.data_byte[bit_idx];
    end else begin
      bit_val = 1'b1;
    end
    if (eff.phase == PH_HEADER) begin
      bit_val = 1'b1;
    end
    half_limit = bit_val ? 3'd4 : 3'd2;

    state_o             = eff;
    result_o.byte_done  = 1'b0;
    result_o.pulse_length = bit_val ? 16'd1 : 16'd2;
    result_o.pulse_level  = LEVEL_LOW;

    case (state_i.phase)
      PH_END: begin
        state_o = state_i;
      end
      default: begin
        if (eff.phase == PH_HEADER) begin
          if (half_inc == 3'd2) begin
            state_o.half_count = '0;
            state_o.bit_count  = bc_inc;
            if (bc_inc == hdr_target) begin
              state_o.phase     = PH_BYTES;
              state_o.bit_count = '0;
            end
          end else begin
            state_o.half_count = half_inc[HALF_W-1:0];
          end
          result_o.pulse_level = {1'b0, state_o.half_count[0]};
        end else begin
          if (half_inc >= half_limit) begin
            state_o.half_count = '0;
            state_o.bit_count  = bc_inc;
            if (bc_inc >= FRAME_BITS) begin
              state_o.bit_count  = '0;
              result_o.byte_done = 1'b1;
              if (item_i.byte_is_last) begin
                state_o.phase = item_i.chunk_is_last ? PH_END : PH_START;
              end
            end
          end else begin
            state_o.half_count = half_inc[HALF_W-1:0];
          end
          result_o.pulse_level = {1'b0, state_o.half_count[0]};
        end
      end
    endcase

    // silence: idle tail after the tape, or the gap ahead of a chunk
    if (state_i.phase == PH_END ||
        (state_i.phase == PH_START && item_i.chunk_has_gap)) begin
      state_o              = eff;
      if (state_i.phase == PH_END) begin
        state_o = state_i;
      end
      result_o.pulse_level  = LEVEL_SILENCE;
      result_o.pulse_length = (cfg_i.gap_length == '0) ? 16'd1 : cfg_i.gap_length;
      result_o.byte_done    = 1'b0;
    end

    result_o.at_end = (state_o.phase == PH_END);
  end

endmodule
`default_nettype wire

// ===== sv/cassette_fsk_pulse_generator.sv =====
// a request beat is registered in the input register, then passes through cfpg_step
// into the output register, from which the master side takes its pulse
// throughput: one request per cycle unless the master side stalls, set by cfpg_step
// a master-side stall reaches s_axis_tready in the same cycle once both registers hold a beat
// reset: header phase with zero counters, header lengths 7936 and 31744, gap length 9600
// config writes take effect on the next clock edge
`default_nettype none
module cassette_fsk_pulse_generator (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [cfpg_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [cfpg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // data_byte
  input  wire logic                                 s_axis_tlast,  // byte_is_last
  // chunk_long_header, chunk_has_gap, chunk_is_last
  input  wire logic [2:0]                           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // pulse_level [1:0], pulse_length [17:2], zero fill [23:18]
  output logic [23:0]                               m_axis_tdata,
  output logic                                      m_axis_tlast,  // byte_done
  output logic                                      m_axis_tuser   // at_end
);
  import cfpg_pkg::*;

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_header_bits <= SHORT_HDR_RST;
      cfg_q.long_header_bits  <= LONG_HDR_RST;
      cfg_q.gap_length        <= GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SHORT_HDR: cfg_q.short_header_bits <= cfg_wdata_i[HDR_W-1:0];
        CFG_LONG_HDR:  cfg_q.long_header_bits  <= cfg_wdata_i[HDR_W-1:0];
        CFG_GAP_LEN:   cfg_q.gap_length        <= cfg_wdata_i[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // item moves from the input register to the output register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.data_byte         <= s_axis_tdata;
      in_q.chunk_long_header <= s_axis_tuser[0];
      in_q.chunk_has_gap     <= s_axis_tuser[1];
      in_q.byte_is_last      <= s_axis_tlast;
      in_q.chunk_is_last     <= s_axis_tuser[2];
    end
  end

  cfpg_step u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_HEADER;
      state_q.bit_count  <= '0;
      state_q.half_count <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.pulse_length, out_q.pulse_level};
  assign m_axis_tlast  = out_q.byte_done;
  assign m_axis_tuser  = out_q.at_end;

  a_silence_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pulse_level == LEVEL_SILENCE |-> !out_q.byte_done)
    else $error("silence beat marked as byte done");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_BYTES |-> state_q.bit_count < FRAME_BITS)
    else $error("bit index past byte frame");

  a_header_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_HEADER |-> state_q.half_count < 2'd2)
    else $error("header half count out of range");

  a_end_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_END |=> state_q.phase == PH_END)
    else $error("left end phase without reset");

  a_done_follows_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && out_d.byte_done |-> state_d.bit_count == '0 && state_d.half_count == '0)
    else $error("byte done without frame restart");

endmodule
`default_nettype wire

// ===== tb/tb_cassette_fsk_pulse_generator.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_cassette_fsk_pulse_generator;
  import cfpg_pkg::*;

  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int RANDOM_REQUESTS = 1450;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tlast;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  cassette_fsk_pulse_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  class pulse_scoreboard;
    logic [HDR_W-1:0] short_hdr;
    logic [HDR_W-1:0] long_hdr;
    logic [GAP_W-1:0] gap_len;
    phase_e phase;
    logic [HDR_W-1:0] bit_cnt;
    logic [HALF_W-1:0] half_cnt;
    out_item_t pending_pulses[$];
    bit last_done;
    int errors;

    function new();
      short_hdr = SHORT_HDR_RST;
      long_hdr = LONG_HDR_RST;
      gap_len = GAP_RST;
      phase = PH_HEADER;
      bit_cnt = '0;
      half_cnt = '0;
      last_done = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_SHORT_HDR: short_hdr = data[HDR_W-1:0];
        CFG_LONG_HDR: long_hdr = data[HDR_W-1:0];
        CFG_GAP_LEN: gap_len = data[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the encoder by one pulse request and queue the pulse it gives
    function void note_request(in_item_t it);
      out_item_t pulse;
      logic [2:0] h;
      logic bit_v;
      pulse = '0;
      bit_v = 1'b1;
      if (phase == PH_END || (phase == PH_START && it.chunk_has_gap)) begin
        if (phase == PH_START) begin
          phase = PH_HEADER;
          bit_cnt = '0;
          half_cnt = '0;
        end
        pulse.pulse_level = LEVEL_SILENCE;
        pulse.pulse_length = (gap_len == '0) ? 16'd1 : gap_len;
      end else begin
        if (phase == PH_START) begin
          phase = PH_HEADER;
          bit_cnt = '0;
          half_cnt = '0;
        end
        h = {1'b0, half_cnt} + 3'd1;
        if (phase == PH_HEADER) begin
          if (h == 3'd2) begin
            h = '0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt == (it.chunk_long_header ? long_hdr : short_hdr)) begin
              phase = PH_BYTES;
              bit_cnt = '0;
            end
          end
        end else begin
          // start bit, data bits lsb first, then stop bits
          if (bit_cnt == '0) bit_v = 1'b0;
          else if (bit_cnt <= 15'd8) bit_v = it.data_byte[bit_cnt - 1'b1];
          if (h >= (bit_v ? 3'd4 : 3'd2)) begin
            h = '0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= FRAME_BITS) begin
              bit_cnt = '0;
              pulse.byte_done = 1'b1;
              if (it.byte_is_last) phase = it.chunk_is_last ? PH_END : PH_START;
            end
          end
        end
        half_cnt = h[HALF_W-1:0];
        pulse.pulse_level = h[0] ? LEVEL_HIGH : LEVEL_LOW;
        pulse.pulse_length = bit_v ? 16'd1 : 16'd2;
      end
      pulse.at_end = (phase == PH_END);
      last_done = pulse.byte_done;
      pending_pulses = {pending_pulses, pulse};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_pulses.size() == 0) begin
        report($sformatf("unexpected pulse level %0d length %0d",
                         got.pulse_level, got.pulse_length));
      end else begin
        want = pending_pulses.pop_front();
        if (got.pulse_level !== want.pulse_level)
          report($sformatf("pulse_level got %0d want %0d", got.pulse_level, want.pulse_level));
        if (got.pulse_length !== want.pulse_length)
          report($sformatf("pulse_length got %0d want %0d",
                           got.pulse_length, want.pulse_length));
        if (got.byte_done !== want.byte_done)
          report($sformatf("byte_done got %0b want %0b", got.byte_done, want.byte_done));
        if (got.at_end !== want.at_end)
          report($sformatf("at_end got %0b want %0b", got.at_end, want.at_end));
      end
    endtask
  endclass

  pulse_scoreboard sb;
  bit quiet;
  int stall;
  int accepted;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // occasional stretches where neither side idles
  always @(posedge clk_i) begin
    if ($urandom_range(255) == 0) quiet = ~quiet;
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  initial begin
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        stall = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pulse_level = m_axis_tdata[1:0];
      got.pulse_length = m_axis_tdata[17:2];
      got.byte_done = m_axis_tlast;
      got.at_end = m_axis_tuser;
      sb.check_result(got);
    end
  end

  task send_request(in_item_t it);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = it.data_byte;
    s_axis_tlast = it.byte_is_last;
    s_axis_tuser = {it.chunk_is_last, it.chunk_has_gap, it.chunk_long_header};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(it);
    accepted++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_pulses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(addr, data);
  endtask

  // feed one chunk, advancing to the next byte whenever a pulse finishes one
  task run_chunk(int nbytes, bit long_hdr, bit has_gap, bit last, int noise_pct,
                 int fixed_byte);
    int idx;
    logic [7:0] cur;
    in_item_t it;
    bit noisy;
    idx = 0;
    cur = (fixed_byte >= 0) ? fixed_byte[7:0] : 8'($urandom);
    while (1) begin
      noisy = ($urandom_range(99) < noise_pct);
      it.data_byte = noisy ? 8'($urandom) : cur;
      it.chunk_long_header = long_hdr;
      it.chunk_has_gap = has_gap;
      it.byte_is_last = (idx >= nbytes - 1);
      it.chunk_is_last = last;
      if (noisy && sb.phase == PH_BYTES) begin
        it.chunk_long_header = 1'($urandom);
        it.chunk_has_gap = 1'($urandom);
      end
      if (noisy && !last) begin
        // a chunk cut short, or a stray last-chunk flag on a middle byte
        if ($urandom_range(7) == 0) it.byte_is_last = 1'b1;
        else if (!it.byte_is_last) it.chunk_is_last = 1'($urandom);
      end
      send_request(it);
      if (sb.last_done) begin
        if (sb.phase == PH_START || sb.phase == PH_END) break;
        idx++;
        cur = (fixed_byte >= 0) ? fixed_byte[7:0] : 8'($urandom);
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_header();
    int r;
    r = $urandom_range(99);
    if (r < 80) return CFG_DATA_W'($urandom_range(6, 1));
    if (r < 95) return CFG_DATA_W'($urandom_range(40, 7));
    return CFG_DATA_W'($urandom_range(200, 41));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gap();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd1;
    if (r == 1) return 16'hffff;
    return CFG_DATA_W'($urandom_range(65535, 1));
  endfunction

  initial begin
    in_item_t it;
    int base;
    sb = new();
    quiet = 1'b0;
    accepted = 0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_SHORT_HDR, 16'd3);
    // first chunk; its gap flag must be ignored
    run_chunk(1, 1'b0, 1'b1, 1'b0, 0, 8'h00);
    // silence at the reset gap length
    it = '0;
    it.data_byte = 8'hff;
    it.chunk_has_gap = 1'b1;
    send_request(it);
    drain();
    write_reg(CFG_SHORT_HDR, 16'd4);
    write_reg(CFG_LONG_HDR, 16'd5);
    write_reg(CFG_GAP_LEN, 16'h0000);
    run_chunk(1, 1'b1, 1'b0, 1'b0, 0, 8'ha5);
    drain();
    // zero gap length becomes a one-unit silence
    run_chunk(1, 1'b0, 1'b1, 1'b0, 0, 8'h5a);
    drain();
    write_reg(CFG_SHORT_HDR, 16'd1);
    write_reg(CFG_LONG_HDR, 16'd2);
    write_reg(CFG_GAP_LEN, 16'hffff);
    run_chunk(2, 1'b0, 1'b1, 1'b0, 0, 8'hff);
    run_chunk(1, 1'b1, 1'b0, 1'b0, 0, -1);

    base = accepted;
    while (accepted - base < RANDOM_REQUESTS) begin
      if ($urandom_range(3) == 0) begin
        drain();
        if ($urandom_range(1)) write_reg(CFG_SHORT_HDR, pick_header());
        if ($urandom_range(1)) write_reg(CFG_LONG_HDR, pick_header());
        if ($urandom_range(1)) write_reg(CFG_GAP_LEN, pick_gap());
      end
      run_chunk($urandom_range(4, 1), 1'($urandom), 1'($urandom), 1'b0,
                ($urandom_range(2) == 0) ? 30 : 5, -1);
    end

    // final chunk, then the endless silence with all fields ignored
    run_chunk(2, 1'($urandom), 1'($urandom), 1'b1, 10, -1);
    repeat (12) begin
      it = in_item_t'($urandom);
      send_request(it);
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/cfpg_pkg.sv
sv/cfpg_step.sv
sv/cassette_fsk_pulse_generator.sv
tb/tb_cassette_fsk_pulse_generator.sv
